// ===== rtl/pzw_pkg.sv =====
// Shared constants and item types for the neutrino pz solver.
`default_nettype none
package pzw_pkg;

    localparam int MOM_W     = 24;   // momentum field width
    localparam int E_W       = 23;   // energy field width
    localparam int WM_W      = 16;   // W mass register width
    localparam logic [WM_W-1:0] WM_RESET = 16'd5126;
    localparam int PT_W      = 48;   // squared transverse momentum
    localparam int T_W       = 49;   // magnitude of twice mu
    localparam int BASE_W    = 74;   // signed twice-mu times lepton pz
    localparam int A_W       = 146;  // first discriminant term
    localparam int B_W       = 142;  // second term before the factor of four
    localparam int RAD_W     = 146;  // radicand
    localparam int ROOT_W    = 73;   // square root
    localparam int REM_W     = 77;   // root remainder
    localparam int SQ_CELLS  = 73;
    localparam int N_W       = 76;   // signed numerator
    localparam int U_W       = 75;   // numerator magnitude
    localparam int DSH_W     = 72;   // divisor times 2^23
    localparam int DIV_CELLS = 24;

    localparam logic [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [MOM_W-1:0] lepton_px;
        logic signed [MOM_W-1:0] lepton_py;
        logic signed [MOM_W-1:0] lepton_pz;
        logic        [E_W-1:0]   lepton_energy;
        logic signed [MOM_W-1:0] missing_px;
        logic signed [MOM_W-1:0] missing_py;
    } t_in;

    typedef struct packed {
        logic signed [MOM_W-1:0] pz_small;
        logic signed [MOM_W-1:0] pz_large;
        logic                    complex_flag;
        logic                    invalid_flag;
    } t_out;

    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic        [PT_W-1:0]   ptl2;
        logic                     cplx;
        logic                     zero;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        t_side             side;
    } t_sq;

    typedef struct packed {
        logic [U_W-1:0]       rem;
        logic [DSH_W-1:0]     dcur;
        logic [DIV_CELLS-1:0] q;
        logic                 neg;
        logic                 sat;
        logic                 cplx;
        logic                 zero;
    } t_dv;

endpackage
`default_nettype wire

// ===== rtl/pzw_front.sv =====
// Multiplier pipeline: builds the discriminant, the root base and the divisor.
`default_nettype none
module pzw_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  pzw_pkg::t_in              i_d,
    input  wire [pzw_pkg::WM_W-1:0]   i_w_mass,
    output logic                      o_valid,
    output pzw_pkg::t_sq              o_d
);
    import pzw_pkg::*;

    logic [8:0] r_vld;

    // stage 1
    logic signed [47:0] r1_lxx, r1_lyy, r1_nxx, r1_nyy, r1_lxnx, r1_lyny, r1_lzz;
    logic [45:0]        r1_ee;
    logic [31:0]        r1_mw2;
    logic signed [MOM_W-1:0] r1_lz;
    // stage 2
    logic [PT_W-1:0]    r2_ptl2, r2_ptn2;
    logic signed [50:0] r2_tm;
    logic signed [47:0] r2_lzz;
    logic [45:0]        r2_ee;
    logic signed [MOM_W-1:0] r2_lz;
    // stage 3
    logic [T_W-1:0]     r3_t;
    logic               r3_tneg, r3_lzneg, r3_zero;
    logic [MOM_W-1:0]   r3_lzm;
    logic [PT_W-1:0]    r3_lz2pt, r3_ptl2;
    logic [47:0]        r3_pm [4];
    // stage 4
    logic [93:0]        r4_p;
    logic [47:0]        r4_hh, r4_bh;
    logic [48:0]        r4_hl, r4_bl;
    logic [49:0]        r4_ll;
    logic               r4_bneg, r4_zero;
    logic [PT_W-1:0]    r4_lz2pt, r4_ptl2;
    // stage 5
    logic [97:0]        r5_t2;
    logic signed [BASE_W-1:0] r5_base;
    logic [47:0]        r5_pp [4][2];
    logic [PT_W-1:0]    r5_lz2pt, r5_ptl2;
    logic               r5_zero;
    // stage 6
    logic [48:0]        r6_pp [4][2];
    logic [71:0]        r6_row [4];
    logic signed [BASE_W-1:0] r6_base;
    logic [PT_W-1:0]    r6_ptl2;
    logic               r6_zero;
    // stage 7
    logic [72:0]        r7_row [4];
    logic [B_W-1:0]     r7_b;
    logic signed [BASE_W-1:0] r7_base;
    logic [PT_W-1:0]    r7_ptl2;
    logic               r7_zero;
    // stage 8
    logic [A_W-1:0]     r8_a;
    logic [B_W-1:0]     r8_b;
    logic signed [BASE_W-1:0] r8_base;
    logic [PT_W-1:0]    r8_ptl2;
    logic               r8_zero;
    // stage 9
    t_sq                r9_d;

    logic signed [50:0]   n_tm;
    logic [72:0]          n_bmag;
    logic [95:0]          n_ppad;
    logic [99:0]          n_t2pad;
    logic [143:0]         n_b;
    logic [147:0]         n_a;
    logic signed [A_W:0]  n_disc;

    always_comb begin
        n_tm = 51'(r1_mw2) + (51'(r1_lxnx) <<< 1) + (51'(r1_lyny) <<< 1);
        n_bmag = (73'(r4_bh) << 25) + 73'(r4_bl);
        n_ppad = {2'b00, r4_p};
        n_t2pad = {2'b00, r5_t2};
        n_b = '0;
        for (int i = 0; i < 4; i++) begin
            n_b = n_b + (144'(r6_row[i]) << (24 * i));
        end
        n_a = '0;
        for (int i = 0; i < 4; i++) begin
            n_a = n_a + (148'(r7_row[i]) << (25 * i));
        end
        n_disc = $signed({1'b0, r8_a}) - $signed({3'b000, r8_b, 2'b00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squares and cross products
            r1_lxx  <= 48'(i_d.lepton_px * i_d.lepton_px);
            r1_lyy  <= 48'(i_d.lepton_py * i_d.lepton_py);
            r1_nxx  <= 48'(i_d.missing_px * i_d.missing_px);
            r1_nyy  <= 48'(i_d.missing_py * i_d.missing_py);
            r1_lxnx <= 48'(i_d.lepton_px * i_d.missing_px);
            r1_lyny <= 48'(i_d.lepton_py * i_d.missing_py);
            r1_lzz  <= 48'(i_d.lepton_pz * i_d.lepton_pz);
            r1_ee   <= 46'(i_d.lepton_energy * i_d.lepton_energy);
            r1_mw2  <= 32'(i_w_mass * i_w_mass);
            r1_lz   <= i_d.lepton_pz;

            r2_ptl2 <= $unsigned(r1_lxx) + $unsigned(r1_lyy);
            r2_ptn2 <= $unsigned(r1_nxx) + $unsigned(r1_nyy);
            r2_tm   <= n_tm;
            r2_lzz  <= r1_lzz;
            r2_ee   <= r1_ee;
            r2_lz   <= r1_lz;

            // magnitudes, energy-times-neutrino partials
            r3_t     <= r2_tm[50] ? T_W'(-r2_tm) : T_W'(r2_tm);
            r3_tneg  <= r2_tm[50];
            r3_lzm   <= r2_lz[MOM_W-1] ? MOM_W'(-r2_lz) : MOM_W'(r2_lz);
            r3_lzneg <= r2_lz[MOM_W-1];
            r3_lz2pt <= $unsigned(r2_lzz) + r2_ptl2;
            r3_zero  <= (r2_ptl2 == '0);
            r3_ptl2  <= r2_ptl2;
            r3_pm[0] <= 48'(r2_ee[23:0]  * r2_ptn2[23:0]);
            r3_pm[1] <= 48'(r2_ee[23:0]  * r2_ptn2[47:24]);
            r3_pm[2] <= 48'(r2_ee[45:24] * r2_ptn2[23:0]);
            r3_pm[3] <= 48'(r2_ee[45:24] * r2_ptn2[47:24]);

            r4_p     <= 94'(r3_pm[0]) + (94'(r3_pm[1]) << 24) + (94'(r3_pm[2]) << 24)
                        + (94'(r3_pm[3]) << 48);
            r4_hh    <= 48'(r3_t[48:25] * r3_t[48:25]);
            r4_hl    <= 49'(r3_t[48:25] * r3_t[24:0]);
            r4_ll    <= 50'(r3_t[24:0] * r3_t[24:0]);
            r4_bh    <= 48'(r3_t[48:25] * r3_lzm);
            r4_bl    <= 49'(r3_t[24:0] * r3_lzm);
            r4_bneg  <= r3_tneg ^ r3_lzneg;
            r4_zero  <= r3_zero;
            r4_lz2pt <= r3_lz2pt;
            r4_ptl2  <= r3_ptl2;

            r5_t2    <= (98'(r4_hh) << 50) + (98'(r4_hl) << 26) + 98'(r4_ll);
            r5_base  <= r4_bneg ? -$signed({1'b0, n_bmag}) : $signed({1'b0, n_bmag});
            for (int i = 0; i < 4; i++) begin
                r5_pp[i][0] <= 48'(n_ppad[24*i +: 24] * r4_ptl2[23:0]);
                r5_pp[i][1] <= 48'(n_ppad[24*i +: 24] * r4_ptl2[47:24]);
            end
            r5_lz2pt <= r4_lz2pt;
            r5_ptl2  <= r4_ptl2;
            r5_zero  <= r4_zero;

            for (int i = 0; i < 4; i++) begin
                r6_pp[i][0] <= 49'(n_t2pad[25*i +: 25] * r5_lz2pt[23:0]);
                r6_pp[i][1] <= 49'(n_t2pad[25*i +: 25] * r5_lz2pt[47:24]);
                r6_row[i]   <= 72'(r5_pp[i][0]) + (72'(r5_pp[i][1]) << 24);
            end
            r6_base <= r5_base;
            r6_ptl2 <= r5_ptl2;
            r6_zero <= r5_zero;

            for (int i = 0; i < 4; i++) begin
                r7_row[i] <= 73'(r6_pp[i][0]) + (73'(r6_pp[i][1]) << 24);
            end
            r7_b    <= n_b[B_W-1:0];
            r7_base <= r6_base;
            r7_ptl2 <= r6_ptl2;
            r7_zero <= r6_zero;

            r8_a    <= n_a[A_W-1:0];
            r8_b    <= r7_b;
            r8_base <= r7_base;
            r8_ptl2 <= r7_ptl2;
            r8_zero <= r7_zero;

            // negative discriminant: take a zero root so both roots fall on the base
            r9_d.rem       <= '0;
            r9_d.root      <= '0;
            r9_d.rad       <= n_disc[A_W] ? '0 : n_disc[RAD_W-1:0];
            r9_d.side.base <= r8_base;
            r9_d.side.ptl2 <= r8_ptl2;
            r9_d.side.cplx <= n_disc[A_W];
            r9_d.side.zero <= r8_zero;
        end
    end

    assign o_valid = r_vld[8];
    assign o_d     = r9_d;

endmodule
`default_nettype wire

// ===== rtl/pzw_sqrt_cell.sv =====
// One square-root cell: settles one root bit from two radicand bits.
`default_nettype none
module pzw_sqrt_cell (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  pzw_pkg::t_sq i_d,
    output logic         o_valid,
    output pzw_pkg::t_sq o_d
);
    import pzw_pkg::*;

    logic             r_valid;
    t_sq              r_d;
    t_sq              n_d;
    logic [REM_W-1:0] w_r;
    logic [REM_W-1:0] w_t;

    always_comb begin
        w_r = {i_d.rem[REM_W-3:0], i_d.rad[RAD_W-1 -: 2]};
        w_t = {{(REM_W-ROOT_W-2){1'b0}}, i_d.root, 2'b01};
        n_d = i_d;
        n_d.rad = {i_d.rad[RAD_W-3:0], 2'b00};
        if (w_r >= w_t) begin
            n_d.rem  = w_r - w_t;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = w_r;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule
`default_nettype wire

// ===== rtl/pzw_div_cell.sv =====
// One divider cell: settles one quotient bit and halves the divisor.
`default_nettype none
module pzw_div_cell (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  pzw_pkg::t_dv i_d,
    output logic         o_valid,
    output pzw_pkg::t_dv o_d
);
    import pzw_pkg::*;

    logic           r_valid;
    t_dv            r_d;
    t_dv            n_d;
    logic [U_W-1:0] w_dx;

    always_comb begin
        w_dx = {{(U_W-DSH_W){1'b0}}, i_d.dcur};
        n_d = i_d;
        n_d.dcur = i_d.dcur >> 1;
        if (i_d.rem >= w_dx) begin
            n_d.rem = i_d.rem - w_dx;
            n_d.q   = {i_d.q[DIV_CELLS-2:0], 1'b1};
        end else begin
            n_d.q   = {i_d.q[DIV_CELLS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule
`default_nettype wire

// ===== rtl/neutrino_pz_w_mass_constraint.sv =====
// Top level of the W-mass-constrained neutrino pz solver.
//
// Usage:
//   Input channel (i_valid / o_stall / i_in): one event per item, lepton
//   momentum and energy plus missing transverse momentum, 1/64 GeV counts.
//   Output channel (o_valid / i_stall / o_out): both pz roots, smaller
//   first, with the complex and invalid flags.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): W mass, write
//   only while no item is in flight; ready is always high.
// Pipeline: 9 multiplier stages, 73 square-root cells, 3 numerator
//   stages, 24 divider cells and 1 output register.
// Throughput: one item per cycle unless i_stall freezes the pipe;
//   every stage is a pipeline register and the square root and both
//   divisions run as chains of one-bit cells.
// Stall: i_stall with a full output register freezes the whole pipeline;
//   an item that arrives in that cycle lands in the input skid register,
//   and o_stall (the skid being full) holds off the next one.
// Reset: synchronous, active low; clears all valid bits, empties the skid
//   register and loads the W mass with its default of 5126 (80.09 GeV).
`default_nettype none
module neutrino_pz_w_mass_constraint (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  pzw_pkg::t_in            i_in,
    output logic                    o_valid,
    input  wire                     i_stall,
    output pzw_pkg::t_out           o_out,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [pzw_pkg::WM_W-1:0] i_cfg_data
);
    import pzw_pkg::*;

    logic [WM_W-1:0] r_w_mass;
    logic            r_skid_full;
    t_in             r_skid;
    logic            w_en;
    logic            w_pv;
    t_in             w_pd;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_mass <= WM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_w_mass <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // advance the whole pipe unless the output register is full and held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = r_skid_full;
    assign w_pv    = r_skid_full || i_valid;
    assign w_pd    = r_skid_full ? r_skid : i_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (w_en) begin
            r_skid_full <= 1'b0;
        end else if (i_valid && !r_skid_full) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && i_valid && !r_skid_full) begin
            r_skid <= i_in;
        end
    end

    // products, discriminant and root base
    logic w_sv [SQ_CELLS+1];
    t_sq  w_sq [SQ_CELLS+1];

    pzw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_pv),
        .i_d      (w_pd),
        .i_w_mass (r_w_mass),
        .o_valid  (w_sv[0]),
        .o_d      (w_sq[0])
    );

    // square root, one bit per cell
    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
        pzw_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[k]),
            .i_d     (w_sq[k]),
            .o_valid (w_sv[k+1]),
            .o_d     (w_sq[k+1])
        );
    end

    // numerators: base -/+ root, offset by the half divisor for rounding
    logic [2:0]              r_pv;
    logic signed [N_W-1:0]   r1_n [2];
    logic [PT_W-1:0]         r1_ptl2, r2_ptl2;
    logic                    r1_cplx, r1_zero, r2_cplx, r2_zero;
    logic [U_W-1:0]          r2_u [2];
    logic                    r2_neg [2];
    t_dv                     r3_d [2];
    logic [DSH_W-1:0]        w_dsh;
    logic signed [N_W-1:0]   w_b, w_s, w_p;

    assign w_b   = N_W'(w_sq[SQ_CELLS].side.base);
    assign w_s   = $signed({{(N_W-ROOT_W){1'b0}}, w_sq[SQ_CELLS].root});
    assign w_p   = $signed({{(N_W-PT_W){1'b0}}, w_sq[SQ_CELLS].side.ptl2});
    assign w_dsh = {r2_ptl2, {(DSH_W-PT_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_en) begin
            r_pv <= {r_pv[1:0], w_sv[SQ_CELLS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_n[0] <= w_b - w_s + w_p;
            r1_n[1] <= w_b + w_s + w_p;
            r1_ptl2 <= w_sq[SQ_CELLS].side.ptl2;
            r1_cplx <= w_sq[SQ_CELLS].side.cplx;
            r1_zero <= w_sq[SQ_CELLS].side.zero;

            for (int j = 0; j < 2; j++) begin
                r2_u[j]   <= r1_n[j][N_W-1] ? U_W'(-r1_n[j]) : U_W'(r1_n[j]);
                r2_neg[j] <= r1_n[j][N_W-1];
            end
            r2_ptl2 <= r1_ptl2;
            r2_cplx <= r1_cplx;
            r2_zero <= r1_zero;

            // quotient outside the signed 24-bit pz range means the root saturates
            for (int j = 0; j < 2; j++) begin
                r3_d[j].rem  <= r2_u[j];
                r3_d[j].dcur <= w_dsh;
                r3_d[j].q    <= '0;
                r3_d[j].neg  <= r2_neg[j];
                r3_d[j].sat  <= r2_neg[j] ? (r2_u[j] > U_W'(w_dsh))
                                          : (r2_u[j] >= U_W'(w_dsh));
                r3_d[j].cplx <= r2_cplx;
                r3_d[j].zero <= r2_zero;
            end
        end
    end

    // two divider rows, one per root
    logic w_dvv [2][DIV_CELLS+1];
    t_dv  w_dv  [2][DIV_CELLS+1];

    for (genvar j = 0; j < 2; j++) begin : g_lane
        assign w_dvv[j][0] = r_pv[2];
        assign w_dv[j][0]  = r3_d[j];
        for (genvar k = 0; k < DIV_CELLS; k++) begin : g_dv
            pzw_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_dvv[j][k]),
                .i_d     (w_dv[j][k]),
                .o_valid (w_dvv[j][k+1]),
                .o_d     (w_dv[j][k+1])
            );
        end
    end

    // floor for negative numerators, saturation at the field limits
    function automatic logic [MOM_W-1:0] pzw_fin(input t_dv d);
        logic [MOM_W:0] m;
        m = {1'b0, d.q} + {{MOM_W{1'b0}}, (d.rem != '0)};
        if (d.sat) begin
            pzw_fin = d.neg ? MOM_MIN : MOM_MAX;
        end else if (d.neg) begin
            pzw_fin = MOM_W'(-m);
        end else begin
            pzw_fin = d.q;
        end
    endfunction

    logic r_out_valid;
    t_out r_out;
    t_out n_out;
    t_dv  w_l0, w_l1;

    assign w_l0 = w_dv[0][DIV_CELLS];
    assign w_l1 = w_dv[1][DIV_CELLS];

    always_comb begin
        if (w_l0.zero) begin
            n_out.pz_small     = '0;
            n_out.pz_large     = '0;
            n_out.complex_flag = 1'b0;
            n_out.invalid_flag = 1'b1;
        end else begin
            n_out.pz_small     = pzw_fin(w_l0);
            n_out.pz_large     = pzw_fin(w_l1);
            n_out.complex_flag = w_l0.cplx;
            n_out.invalid_flag = w_l0.sat || w_l1.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dvv[0][DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

`ifndef NO_ASSERTIONS
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvv[0][DIV_CELLS] == w_dvv[1][DIV_CELLS])
        else $error("divider rows out of step");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled while output moved");

    a_cplx_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.complex_flag |-> o_out.pz_small == o_out.pz_large)
        else $error("complex result with differing roots");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.invalid_flag |-> $signed(o_out.pz_small) <= $signed(o_out.pz_large))
        else $error("roots out of order");
`endif

endmodule
`default_nettype wire
